>>> src/stbs_pkg.sv
`timescale 1ns / 1ps
package stbs_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int INDEX_W     = 10;
  localparam int COUNT_W     = 11;
  localparam int VALUE_W     = 32;

  // Packed stream widths
  localparam int IN_FIELDS_W = INDEX_W + 2 * VALUE_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((INDEX_W + 7) / 8) * 8;

  // Request kinds carried on in_tuser
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // Controller to datapath
  typedef struct packed {
    logic start;   // latch key, open the search range
    logic write;   // store one table entry
    logic probe;   // register the probe index, read the table
    logic narrow;  // shrink the range after a miss at the probe
    logic hit;     // mark the search as found
    logic emit;    // load the result into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic empty;       // search range holds no entries
    logic key_eq;      // probed entry equals key
    logic out_free;    // output register can take a result
  } dp_sts_t;

endpackage

>>> src/stbs_ram.sv
`timescale 1ns / 1ps
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/stbs_ctrl.sv
`timescale 1ns / 1ps
module stbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_mode,
  output logic              in_tready,
  input  stbs_pkg::dp_sts_t sts,
  output stbs_pkg::dp_cmd_t cmd
);
  import stbs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PROBE  = 4'b0010,
    ST_CMP    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_mode == MODE_SEARCH) begin
          cmd.start = 1'b1;
          state_nxt = ST_PROBE;
        end else if (accept) begin
          cmd.write = 1'b1;
        end
      end
      ST_PROBE: begin
        if (sts.empty) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.probe = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts.key_eq) begin
          cmd.hit   = 1'b1;
          state_nxt = ST_FINISH;
        end else begin
          cmd.narrow = 1'b1;
          state_nxt  = ST_PROBE;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/stbs_dp.sv
`timescale 1ns / 1ps
module stbs_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  stbs_pkg::dp_cmd_t                   cmd,
  output stbs_pkg::dp_sts_t                   sts,
  input  logic                                cfg_valid,
  input  logic [stbs_pkg::COUNT_W-1:0]        cfg_data,
  input  logic [stbs_pkg::INDEX_W-1:0]        in_entry_index,
  input  logic signed [stbs_pkg::VALUE_W-1:0] in_entry_value,
  input  logic signed [stbs_pkg::VALUE_W-1:0] in_search_key,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic                                out_found,
  output logic [stbs_pkg::INDEX_W-1:0]        out_position
);
  import stbs_pkg::*;

  logic [COUNT_W-1:0]        count_r;
  logic signed [VALUE_W-1:0] key_r;
  logic [COUNT_W-1:0]        lo_r;     // first candidate
  logic [COUNT_W-1:0]        hi_r;     // one past last candidate
  logic [ADDR_W-1:0]         mid_r;
  logic                      found_r;
  logic                      out_valid_r;
  logic                      out_found_r;
  logic [INDEX_W-1:0]        out_pos_r;

  logic [COUNT_W-1:0]        span;
  logic [COUNT_W-1:0]        mid_wide;
  logic [ADDR_W-1:0]         mid;
  logic [COUNT_W-1:0]        count_sat;
  logic [VALUE_W-1:0]        rdata;
  logic signed [VALUE_W-1:0] entry;

  // Entry count register, always writable
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_valid) begin
      count_r <= cfg_data;
    end
  end

  assign count_sat = (count_r > COUNT_W'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : count_r;

  // Probe index: lo + floor((hi - 1 - lo) / 2)
  assign span     = hi_r - lo_r - COUNT_W'(1);
  assign mid_wide = lo_r + (span >> 1);
  assign mid      = mid_wide[ADDR_W-1:0];

  stbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (in_entry_index[ADDR_W-1:0]),
    .wdata (in_entry_value),
    .raddr (mid),
    .rdata (rdata)
  );

  assign entry = $signed(rdata);

  // Search range and probe registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r <= in_search_key;
      lo_r  <= '0;
      hi_r  <= count_sat;
    end else if (cmd.narrow) begin
      if (entry < key_r) begin
        lo_r <= {1'b0, mid_r} + COUNT_W'(1);
      end else begin
        hi_r <= {1'b0, mid_r};
      end
    end
    if (cmd.probe) begin
      mid_r <= mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.start) begin
      found_r <= 1'b0;
    end else if (cmd.hit) begin
      found_r <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_found_r <= found_r;
      out_pos_r   <= found_r ? INDEX_W'(mid_r) : '0;
    end
  end

  assign sts.empty    = (lo_r >= hi_r);
  assign sts.key_eq   = (entry == key_r);
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid   = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_pos_r;

endmodule

>>> src/sorted_table_binary_search.sv
`timescale 1ns / 1ps
// Channel  Ports                         Contents
// -------  ----------------------------  ------------------------------------------
// in       in_tvalid/in_tready/...       tuser: mode; tdata: index, value, key
// out      out_tvalid/out_tready/...     tuser: found; tdata: position
// cfg      cfg_valid/cfg_ready/cfg_data  entry_count
//
// A write request is taken in idle and gives no result. A search request
// runs probes (table read, then compare) until a hit or an empty range, up
// to eleven probes at 1024 entries; each probe waits on the registered
// table read and the compare of the probe before it.
// Reset is synchronous: the controller returns to idle, the output is empty
// and entry_count is 0; table contents stay undefined until written.
// A stalled result waits in the output register; the next request is taken
// once the search that produced it has handed over its result.
module sorted_table_binary_search (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [73:42] search_key, [41:10] entry_value, [9:0] entry_index
  input  logic [stbs_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] mode
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [9:0] position
  output logic [stbs_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [0] found
  output logic                                 out_tuser,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [stbs_pkg::COUNT_W-1:0]         cfg_data
);
  import stbs_pkg::*;

  dp_cmd_t            cmd;
  dp_sts_t            sts;
  logic [INDEX_W-1:0] position;

  assign cfg_ready = 1'b1;

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_mode   (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  stbs_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .in_entry_index (in_tdata[INDEX_W-1:0]),
    .in_entry_value (in_tdata[INDEX_W+VALUE_W-1:INDEX_W]),
    .in_search_key  (in_tdata[INDEX_W+2*VALUE_W-1:INDEX_W+VALUE_W]),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_found      (out_tuser),
    .out_position   (position)
  );

  assign out_tdata = OUT_TDATA_W'(position);

endmodule

>>> src/stbs_chk.sv
`timescale 1ns / 1ps
module stbs_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [stbs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser
);
  import stbs_pkg::*;

  // Held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A miss reports position zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("miss with nonzero position");

  // A search request keeps the block busy next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == MODE_SEARCH |=> !in_tready)
    else $error("request taken during search");

  // A write request gives no result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == MODE_WRITE && !out_tvalid |=> !out_tvalid)
    else $error("result after write request");

endmodule

bind sorted_table_binary_search stbs_chk u_chk (.*);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import stbs_pkg::*;

  localparam int     CYCLE_LIMIT = 1000000;
  localparam int     DRAIN_WAIT  = 30;     // longer than one full-depth search
  localparam longint VAL_MAX     = 64'sd2147483647;
  localparam longint VAL_MIN     = -64'sd2147483648;

  // One search outcome: found flag plus matching index
  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] pos;
  } lookup_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    in_tuser;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tuser;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [COUNT_W-1:0]      cfg_data;

  // Shadow of the block's table and entry_count
  logic signed [VALUE_W-1:0] table_copy [TABLE_DEPTH];
  logic [COUNT_W-1:0]        count_copy;
  lookup_t                   pending_lookups[$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_len;
  int unsigned fail_count;
  int unsigned cycle_count;

  sorted_table_binary_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Binary search over the shadow table, probe order as the block runs it
  function automatic lookup_t search_table(input logic signed [VALUE_W-1:0] key);
    int      lo;
    int      hi;
    int      mid;
    lookup_t r;
    r  = '0;
    lo = 0;
    hi = ((count_copy > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_copy)) - 1;
    while (lo <= hi && !r.found) begin
      mid = lo + (hi - lo) / 2;
      if (table_copy[mid] > key) begin
        hi = mid - 1;
      end else if (table_copy[mid] < key) begin
        lo = mid + 1;
      end else begin
        r.found = 1'b1;
        r.pos   = mid[INDEX_W-1:0];
      end
    end
    return r;
  endfunction

  // Offer one request; update the shadow state when it is taken
  task automatic send_req(input logic mode, input logic [INDEX_W-1:0] idx,
                          input logic [VALUE_W-1:0] val, input logic [VALUE_W-1:0] key);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= IN_TDATA_W'({key, val, idx});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (mode == MODE_WRITE) begin
      table_copy[idx] = val;
    end else begin
      pending_lookups.push_back(search_table(key));
    end
  endtask

  // Unused fields carry random bits; the block must ignore them
  task automatic write_entry(input int unsigned idx, input logic [VALUE_W-1:0] val);
    send_req(MODE_WRITE, idx[INDEX_W-1:0], val, $urandom);
  endtask

  task automatic lookup(input logic [VALUE_W-1:0] key);
    send_req(MODE_SEARCH, INDEX_W'($urandom), $urandom, key);
  endtask

  // Drop valid, wait for all results, then let any trailing write settle
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_count(input int unsigned n);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n[COUNT_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    count_copy = n[COUNT_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Fill entries 0..n-1, ascending with steps up to step_max, or random
  task automatic fill_table(input int unsigned n, input int unsigned step_max,
                            input bit scramble);
    longint span;
    longint cur;
    span = longint'(n) * step_max;
    cur  = longint'($signed($urandom));
    if (cur + span > VAL_MAX) cur = VAL_MAX - span;
    if (cur < VAL_MIN) cur = VAL_MIN;
    for (int unsigned i = 0; i < n; i++) begin
      cur += $urandom_range(step_max, 0);
      if (cur > VAL_MAX) cur = VAL_MAX;
      write_entry(i, scramble ? $urandom : cur[VALUE_W-1:0]);
    end
  endtask

  // Mostly keys present in the table, then neighbors, extremes and noise
  function automatic logic [VALUE_W-1:0] pick_key();
    int unsigned eff;
    int unsigned r;
    logic [VALUE_W-1:0] k;
    eff = (count_copy > TABLE_DEPTH) ? TABLE_DEPTH : count_copy;
    r   = $urandom_range(99);
    k   = $urandom;
    if (eff != 0 && r < 70) begin
      k = table_copy[$urandom_range(eff - 1, 0)];
      if (r >= 45) k = ($urandom_range(1)) ? k + 1 : k - 1;
    end else if (r < 80) begin
      k = ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return k;
  endfunction

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // With entry_count at its reset value every search misses
  task automatic test_empty_table();
    lookup(32'h0000_0000);
    lookup(32'h8000_0000);
    lookup(32'h7FFF_FFFF);
  endtask

  // Value extremes, first-probe hit, misses between entries, single entry
  task automatic test_extremes();
    write_entry(0, 32'h8000_0000);
    write_entry(1, 32'hFFFF_FFFF);
    write_entry(2, 32'h0000_0000);
    write_entry(3, 32'h0000_0001);
    write_entry(4, 32'h7FFF_FFFF);
    write_entry(1023, 32'h5A5A_A5A5);
    set_count(5);
    lookup(32'h0000_0000);
    lookup(32'h8000_0000);
    lookup(32'h7FFF_FFFF);
    lookup(32'h0000_0002);
    lookup(32'hFFFF_FFFE);
    set_count(1);
    lookup(32'h8000_0000);
    lookup(32'h0000_0005);
    // out-of-order table: probes still follow the fixed sequence
    write_entry(2, 32'h8000_0000);
    set_count(5);
    lookup(32'h0000_0001);
    lookup(32'h8000_0000);
  endtask

  // Whole table once, then counts at, beyond and below the depth
  task automatic test_full_table();
    fill_table(TABLE_DEPTH, 1 << 22, 1'b0);
    set_count(TABLE_DEPTH);
    repeat (40) lookup(pick_key());
    set_count((1 << COUNT_W) - 1);
    repeat (20) lookup(pick_key());
    set_count($urandom_range(TABLE_DEPTH - 1, 33));
    repeat (20) lookup(pick_key());
  endtask

  // Refill a prefix for counts up to 32, set a count, then searches with stray writes mixed in
  task automatic test_random_rounds(input int unsigned rounds, input bit big_ok);
    int unsigned n;
    int unsigned sel;
    int unsigned step_max;
    for (int unsigned r = 0; r < rounds; r++) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        n = 0;
      end else if (big_ok && sel < 20) begin
        n = $urandom_range((1 << COUNT_W) - 1, 33);
      end else begin
        n = $urandom_range(32, 1);
      end
      case ($urandom_range(3))
        0: step_max = 1;
        1: step_max = 100;
        2: step_max = 1 << 20;
        default: step_max = 1 << 27;
      endcase
      if (n <= 32) fill_table(n, step_max, $urandom_range(9) == 0);
      set_count(n);
      repeat ($urandom_range(32, 16)) begin
        if ($urandom_range(9) == 0) begin
          write_entry($urandom_range(TABLE_DEPTH - 1), $urandom);
        end else begin
          lookup(pick_key());
        end
      end
    end
  endtask

  // Receiver stalls long while requests keep coming, so the input backs up
  task automatic test_output_stall();
    fill_table(16, 1000, 1'b0);
    set_count(16);
    stall_len = 400;
    repeat (30) lookup(pick_key());
  endtask

  // Receiver: random stalls, or a counted long hold-off when requested
  always @(negedge clk) begin
    if (stall_len > 0) begin
      out_tready <= 1'b0;
      stall_len = stall_len - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each delivered result with the oldest prediction
  always @(posedge clk) begin
    lookup_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result, expected none, got found=%0b position=%0d",
                 $time, out_tuser, out_tdata[INDEX_W-1:0]);
        fail_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (out_tuser !== want.found) begin
          $display("%0t: found mismatch, expected %0b, got %0b",
                   $time, want.found, out_tuser);
          fail_count++;
        end
        if (out_tdata[INDEX_W-1:0] !== want.pos) begin
          $display("%0t: position mismatch, expected %0d, got %0d",
                   $time, want.pos, out_tdata[INDEX_W-1:0]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = MODE_WRITE;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    stall_len     = 0;
    fail_count    = 0;
    cycle_count   = 0;
    count_copy    = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) table_copy[i] = '0;
    set_idling(32, 84);
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_extremes();
    test_random_rounds(6, 1'b0);

    set_idling(84, 32);
    test_random_rounds(6, 1'b0);
    test_output_stall();

    set_idling(0, 0);
    test_full_table();
    test_random_rounds(6, 1'b1);

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
